/* hw/rtl/rgpt_pkg.sv */
// Shared word types, result kinds and command codes of the grace period tracker.
package rgpt_pkg;

    localparam logic       ACT_ENQ  = 1'b0;
    localparam logic       ACT_QS   = 1'b1;

    localparam logic [1:0] K_RUN    = 2'd0;
    localparam logic [1:0] K_DONE   = 2'd1;
    localparam logic [1:0] K_REJECT = 2'd2;
    localparam logic [1:0] K_ACCEPT = 2'd3;

    typedef struct packed {
        logic        action;
        logic [2:0]  cpu;
        logic [31:0] handle;
        logic [7:0]  idle_mask;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] handle_res;
        logic [7:0]  wake_mask;
        logic        period_started;
        logic        last;
    } t_out_word;

    typedef enum logic [1:0] {
        OP_ENQ    = 2'd0,
        OP_REJECT = 2'd1,
        OP_REPORT = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [2:0]  cpu;
        logic [31:0] handle;
        logic [7:0]  idle_mask;
    } t_cmd;

endpackage

/* hw/rtl/rcu_grace_period_tracker.sv */
// Enqueue: the accepted input word passes through the command queue and the EXEC state of the
// back end into the registered result word; the back end takes a new command only when the last is done.
// Report: the finish word follows the ready callbacks, read through the single read port of the
// callback memory (one read, then one emitted word, per callback).
// A two-entry command queue takes new words while the back end works; output stalls hold the back end.
// Synchronous active-low reset clears all queues, counters and roles at once.
module rcu_grace_period_tracker import rgpt_pkg::*; #(
    parameter int CPUS        = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [3:0] CNT_RST = 4'((CPUS < 8) ? CPUS : 8);

    logic [3:0] r_cpu_count, n_cpu_count;
    logic       cfg_wr;
    logic       cmd_valid, cmd_pop;
    t_cmd       cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {28'd0, r_cpu_count};

    always_comb begin
        if (pwdata[3:0] == 4'd0) begin
            n_cpu_count = 4'd1;
        end else if (int'(pwdata[3:0]) > CPUS) begin
            n_cpu_count = 4'(CPUS);
        end else begin
            n_cpu_count = pwdata[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu_count <= CNT_RST;
        end else if (cfg_wr) begin
            r_cpu_count <= n_cpu_count;
        end
    end

    rgpt_front #(.CPUS(CPUS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    rgpt_back #(.CPUS(CPUS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cpu_count (r_cpu_count),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cpu_count != 4'd0 && int'(r_cpu_count) <= CPUS)
        else $error("cpu_count out of range");

    a_run_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.kind == K_RUN |-> !o_out_word.last)
        else $error("run word marked last");

    a_start_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.period_started |-> o_out_word.kind == K_DONE)
        else $error("period start on non-finish word");

    a_wake_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.wake_mask != 8'd0 |-> o_out_word.period_started)
        else $error("wake mask without period start");

endmodule

/* hw/rtl/rgpt_front.sv */
// Front end: accepts input words, classifies them and buffers them in a two-entry queue.
module rgpt_front import rgpt_pkg::*; #(
    parameter int CPUS = 8
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_word i_in_word,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       cpu_ok;
    t_cmd       cls;

    always_comb begin
        cpu_ok        = int'(i_in_word.cpu) < CPUS;
        cls.cpu       = i_in_word.cpu;
        cls.handle    = i_in_word.handle;
        cls.idle_mask = i_in_word.idle_mask;
        if (i_in_word.action == ACT_ENQ) begin
            cls.op = (!cpu_ok || i_in_word.handle == 32'd0) ? OP_REJECT : OP_ENQ;
        end else begin
            cls.op = cpu_ok ? OP_REPORT : OP_NOP;
        end
    end

    assign o_in_stall  = (r_cnt == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= cls;
                r_wp      <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_cmd_pop);
        end
    end

endmodule

/* hw/rtl/rgpt_back.sv */
// Back end: sequencer over the per-CPU queues, callback memory and grace period state.
module rgpt_back import rgpt_pkg::*; #(
    parameter int CPUS        = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [3:0] i_cpu_count,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_word  o_out_word
);

    localparam int CW = (CPUS > 1) ? $clog2(CPUS) : 1;
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = CW + 2 + PW;
    localparam int MEM_WORDS = CPUS * 4 * (2 ** PW);

    localparam logic [1:0] R_BATCH = 2'd0;
    localparam logic [1:0] R_WAIT  = 2'd1;
    localparam logic [1:0] R_READY = 2'd2;
    localparam logic [5:0] ROLE_RST = 6'b10_01_00;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_RD   = 5'b00100,
        S_EMIT = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    function automatic logic [1:0] role_get(logic [5:0] m, logic [1:0] r);
        return m[2*r +: 2];
    endfunction

    function automatic logic [5:0] role_swap(logic [5:0] m, logic [1:0] ra, logic [1:0] rb);
        logic [5:0] o;
        o = m;
        o[2*ra +: 2] = m[2*rb +: 2];
        o[2*rb +: 2] = m[2*ra +: 2];
        return o;
    endfunction

    t_state          r_state, n_state;
    t_cmd            r_cmd, n_cmd;
    logic [CPUS-1:0] r_ack, n_ack;
    logic            r_active, n_active;
    logic [63:0]     r_gg, n_gg;
    logic [PW-1:0]   r_head [CPUS][3];
    logic [NW-1:0]   r_cnt  [CPUS][3];
    logic [5:0]      r_role [CPUS];
    logic [63:0]     r_cgr  [CPUS];
    logic [31:0]     mem [MEM_WORDS];
    logic [31:0]     r_rd_data;
    logic            r_out_valid;
    t_out_word       r_out;

    logic [CW-1:0]   cidx;
    logic [PW-1:0]   row_head [3];
    logic [NW-1:0]   row_cnt  [3];
    logic [5:0]      row_role;
    logic [63:0]     row_gr;
    logic            row_we;
    logic            mem_we, rd_en;
    logic [AW-1:0]   mem_wa, rd_addr;
    logic            out_free, emit;
    t_out_word       emit_word;
    logic [1:0]      sb, sr;
    logic [NW:0]     pos_sum;
    logic [PW-1:0]   pos;
    // End-of-report evaluation
    logic            f_wake, f_move, f_start;
    logic [5:0]      f_map1, f_map2;
    logic [7:0]      f_wm;
    logic [CPUS-1:0] f_pmask;

    assign cidx     = CW'(r_cmd.cpu);
    assign out_free = !r_out_valid || !i_out_stall;
    assign sb       = role_get(r_role[cidx], R_BATCH);
    assign sr       = role_get(r_role[cidx], R_READY);

    always_comb begin
        pos_sum = (NW+1)'(r_head[cidx][sb]) + (NW+1)'(r_cnt[cidx][sb]);
        if (int'(pos_sum) >= QUEUE_DEPTH) begin
            pos_sum = pos_sum - (NW+1)'(QUEUE_DEPTH);
        end
        pos = PW'(pos_sum);
    end

    always_comb begin
        f_wake = (r_cnt[cidx][role_get(r_role[cidx], R_WAIT)] != '0) &&
                 ((r_gg > r_cgr[cidx]) || (r_gg == r_cgr[cidx] && !r_active));
        f_map1 = f_wake ? role_swap(r_role[cidx], R_WAIT, R_READY) : r_role[cidx];
        f_move = (r_cnt[cidx][role_get(f_map1, R_WAIT)] == '0) &&
                 (r_cnt[cidx][role_get(f_map1, R_BATCH)] != '0);
        f_map2 = f_move ? role_swap(f_map1, R_BATCH, R_WAIT) : f_map1;
        f_start = (r_cnt[cidx][role_get(f_map2, R_WAIT)] != '0) && !r_active;
        for (int i = 0; i < CPUS; i++) begin
            f_pmask[i] = i < int'(i_cpu_count);
        end
        for (int j = 0; j < 8; j++) begin
            f_wm[j] = r_cmd.idle_mask[j] && (j < int'(i_cpu_count));
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_ack     = r_ack;
        n_active  = r_active;
        n_gg      = r_gg;
        row_head  = r_head[cidx];
        row_cnt   = r_cnt[cidx];
        row_role  = r_role[cidx];
        row_gr    = r_cgr[cidx];
        row_we    = 1'b0;
        mem_we    = 1'b0;
        mem_wa    = {cidx, sb, pos};
        rd_en     = 1'b0;
        rd_addr   = {cidx, sr, r_head[cidx][sr]};
        emit      = 1'b0;
        emit_word = '0;
        emit_word.last = 1'b1;
        o_cmd_pop = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_cmd.op)
                    OP_ENQ: begin
                        if (out_free) begin
                            emit = 1'b1;
                            if (int'(r_cnt[cidx][sb]) >= QUEUE_DEPTH) begin
                                emit_word.kind = K_REJECT;
                            end else begin
                                mem_we         = 1'b1;
                                row_cnt[sb]    = r_cnt[cidx][sb] + NW'(1);
                                row_we         = 1'b1;
                                emit_word.kind = K_ACCEPT;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    OP_REJECT: begin
                        if (out_free) begin
                            emit           = 1'b1;
                            emit_word.kind = K_REJECT;
                            n_state        = S_IDLE;
                        end
                    end
                    OP_NOP: begin
                        if (out_free) begin
                            emit           = 1'b1;
                            emit_word.kind = K_DONE;
                            n_state        = S_IDLE;
                        end
                    end
                    OP_REPORT: begin
                        if (r_active && r_ack[cidx]) begin
                            n_ack[cidx] = 1'b0;
                            if (n_ack == '0) begin
                                n_active = 1'b0;
                            end
                        end
                        n_state = S_RD;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_RD: begin
                if (r_cnt[cidx][sr] == '0) begin
                    n_state = S_FIN;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    emit                 = 1'b1;
                    emit_word.kind       = K_RUN;
                    emit_word.handle_res = r_rd_data;
                    emit_word.last       = 1'b0;
                    row_head[sr] = (r_head[cidx][sr] == PW'(QUEUE_DEPTH - 1)) ?
                                   '0 : r_head[cidx][sr] + PW'(1);
                    row_cnt[sr]  = r_cnt[cidx][sr] - NW'(1);
                    row_we       = 1'b1;
                    n_state      = S_RD;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    emit           = 1'b1;
                    emit_word.kind = K_DONE;
                    row_role       = f_map2;
                    row_we         = 1'b1;
                    if (f_move) begin
                        row_gr = r_gg + 64'd1;
                    end
                    if (f_start) begin
                        n_active = 1'b1;
                        n_gg     = r_gg + 64'd1;
                        n_ack    = f_pmask;
                        emit_word.wake_mask      = f_wm;
                        emit_word.period_started = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= r_cmd.handle;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
        if (emit) begin
            r_out <= emit_word;
        end
        r_cmd <= n_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ack       <= '0;
            r_active    <= 1'b0;
            r_gg        <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CPUS; c++) begin
                for (int q = 0; q < 3; q++) begin
                    r_head[c][q] <= '0;
                    r_cnt[c][q]  <= '0;
                end
                r_role[c] <= ROLE_RST;
                r_cgr[c]  <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_ack    <= n_ack;
            r_active <= n_active;
            r_gg     <= n_gg;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (row_we) begin
                r_head[cidx] <= row_head;
                r_cnt[cidx]  <= row_cnt;
                r_role[cidx] <= row_role;
                r_cgr[cidx]  <= row_gr;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

/* bench/tb_rcu_grace_period_tracker.sv */
// Self-checking testbench of the grace period tracker with its own predictor.
module tb_rcu_grace_period_tracker import rgpt_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCPU  = 8;
    localparam int DEPTH = 16;

    // Result scoreboard: holds the words the tracker is expected to emit.
    class grace_board;
        t_out_word pending[$];
        int        errors;
        int        words_seen;

        function void note_word(t_out_word w);
            pending.push_back(w);
        endfunction

        task report_bad(string what, t_out_word e, t_out_word g);
            errors++;
            $display("MISMATCH %s: expected %h got %h at %0t", what, e, g, $time);
        endtask

        task check_word(t_out_word got);
            t_out_word exp_w;
            words_seen++;
            if (pending.size() == 0) begin
                report_bad("unexpected word", 0, got);
                return;
            end
            exp_w = pending.pop_front();
            if (got.kind !== exp_w.kind) report_bad("kind", exp_w, got);
            else if (got.handle_res !== exp_w.handle_res) report_bad("handle", exp_w, got);
            else if (got.wake_mask !== exp_w.wake_mask) report_bad("wake_mask", exp_w, got);
            else if (got.period_started !== exp_w.period_started)
                report_bad("period_started", exp_w, got);
            else if (got.last !== exp_w.last) report_bad("last", exp_w, got);
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    t_in_word    i_in_word = '0;
    logic        o_out_valid;
    logic        i_out_stall = 0;
    t_out_word   o_out_word;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    rcu_grace_period_tracker i_dut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    // Predictor state.
    logic [3:0]  m_cpu_count;
    logic [7:0]  m_ack;
    logic [63:0] m_grace;
    logic        m_active;
    logic [63:0] m_cpu_grace [NCPU];
    logic [31:0] m_store [NCPU*3][DEPTH];
    int          m_head [NCPU*3];
    int          m_count [NCPU*3];
    int          m_role [NCPU][3];

    grace_board board = new();
    int sender_idle, receiver_idle;
    int accepted;

    function automatic void push_word(logic [1:0] k, logic [31:0] h, logic [7:0] wm,
                                      logic ps, logic lst);
        t_out_word w;
        w.kind = k; w.handle_res = h; w.wake_mask = wm;
        w.period_started = ps; w.last = lst;
        board.note_word(w);
    endfunction

    function automatic void swap_roles(int c, int a, int b);
        int t;
        t = m_role[c][a]; m_role[c][a] = m_role[c][b]; m_role[c][b] = t;
    endfunction

    function automatic void predict_word(t_in_word w);
        int c, qb, qw, qr;
        bit wake;
        logic [7:0] part, wm;
        logic ps;
        c = w.cpu;
        part = 8'((16'd1 << m_cpu_count) - 1);
        if (w.action == ACT_ENQ) begin
            qb = c*3 + m_role[c][0];
            if (w.handle == 0 || m_count[qb] >= DEPTH) begin
                push_word(K_REJECT, 0, 0, 0, 1);
            end else begin
                m_store[qb][(m_head[qb] + m_count[qb]) % DEPTH] = w.handle;
                m_count[qb]++;
                push_word(K_ACCEPT, 0, 0, 0, 1);
            end
            return;
        end
        if (m_active && m_ack[c]) begin
            m_ack[c] = 0;
            if (m_ack == 0) m_active = 0;
        end
        qw = c*3 + m_role[c][1];
        wake = m_count[qw] != 0 && (m_grace > m_cpu_grace[c] ||
               (m_grace == m_cpu_grace[c] && !m_active));
        qr = c*3 + m_role[c][2];
        while (m_count[qr] != 0) begin
            push_word(K_RUN, m_store[qr][m_head[qr]], 0, 0, 0);
            m_head[qr] = (m_head[qr] + 1) % DEPTH;
            m_count[qr]--;
        end
        if (wake) swap_roles(c, 1, 2);
        qw = c*3 + m_role[c][1];
        qb = c*3 + m_role[c][0];
        if (m_count[qw] == 0 && m_count[qb] != 0) begin
            swap_roles(c, 0, 1);
            m_cpu_grace[c] = m_grace + 1;
        end
        qw = c*3 + m_role[c][1];
        wm = 0; ps = 0;
        if (m_count[qw] != 0 && !m_active) begin
            m_active = 1;
            m_grace = m_grace + 1;
            m_ack = part;
            wm = w.idle_mask & part;
            ps = 1;
        end
        push_word(K_DONE, 0, wm, ps, 1);
    endfunction

    task automatic write_cpu_count(logic [31:0] v);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= 0; pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        v = v & 32'hF;
        if (v < 1) v = 1;
        if (v > NCPU) v = NCPU;
        m_cpu_count = v[3:0];
    endtask

    // Valid stays high after an accepted word unless the sender idles or the batch ends.
    task automatic send_word(t_in_word w);
        while (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_word(w);
        accepted++;
    endtask

    task automatic send_item(bit act, int c, logic [31:0] h, logic [7:0] idle);
        t_in_word w;
        w.action = act; w.cpu = c[2:0]; w.handle = h; w.idle_mask = idle;
        send_word(w);
    endtask

    task automatic drain_results();
        i_in_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // Output side: random stall, check each accepted word.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) board.check_word(o_out_word);
            i_out_stall <= ($urandom_range(99) < receiver_idle);
        end
    end

    task automatic random_items(int n);
        int c;
        for (int i = 0; i < n; i++) begin
            c = $urandom_range(NCPU-1);
            // Mostly well-formed traffic: enqueues and reports spread over CPUs.
            case ($urandom_range(9))
                0:       send_item(ACT_ENQ, c, 0, 8'($urandom));
                1, 2, 3: send_item(ACT_ENQ, c, $urandom, 8'($urandom));
                default: send_item(ACT_QS, c, $urandom, 8'($urandom));
            endcase
        end
    endtask

    initial begin
        m_cpu_count = 8; m_ack = 0; m_grace = 0; m_active = 0;
        for (int c = 0; c < NCPU; c++) begin
            m_cpu_grace[c] = 0;
            m_role[c][0] = 0; m_role[c][1] = 1; m_role[c][2] = 2;
        end
        for (int q = 0; q < NCPU*3; q++) begin
            m_head[q] = 0; m_count[q] = 0;
        end
        sender_idle = 18; receiver_idle = 77; accepted = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        repeat (2) @(posedge i_clk);

        // Directed: extremes, null handle, full queue, period start and end.
        send_item(ACT_ENQ, 0, 0, 8'hFF);
        send_item(ACT_ENQ, 0, 32'hFFFF_FFFF, 0);
        send_item(ACT_ENQ, 7, 32'h1, 8'hFF);
        send_item(ACT_QS, 0, 32'hFFFF_FFFF, 8'hFF);
        for (int i = 0; i < 17; i++) send_item(ACT_ENQ, 3, 32'h100 + i, 8'h55);
        send_item(ACT_QS, 3, 0, 8'hAA);
        for (int c = 0; c < NCPU; c++) send_item(ACT_QS, c, 0, 8'h00);
        drain_results();

        write_cpu_count(1);
        random_items(25);
        drain_results();
        sender_idle = 77; receiver_idle = 18;
        write_cpu_count(32'hF);
        random_items(25);
        drain_results();
        sender_idle = 0; receiver_idle = 0;
        write_cpu_count(0);
        random_items(20);
        drain_results();
        write_cpu_count(8);
        random_items(20);
        drain_results();

        $display("Covered %0d input words and %0d result words over cpu_count 1, 8 and",
                 accepted, board.words_seen);
        $display("saturated writes, with rejects, full queues and period starts.");
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

/* rcu_grace_period_tracker.f */
hw/rtl/rgpt_pkg.sv
hw/rtl/rgpt_front.sv
hw/rtl/rgpt_back.sv
hw/rtl/rcu_grace_period_tracker.sv
bench/tb_rcu_grace_period_tracker.sv
